// ----- rtl/x86dec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package x86dec_pkg;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_MODRM   = 3'd1,
      PH_DISP_LO = 3'd2,
      PH_DISP_HI = 3'd3,
      PH_IMM_LO  = 3'd4,
      PH_IMM_HI  = 3'd5
   } phase_type;

   localparam logic [1:0] ST_DECODED = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;

   localparam logic [2:0] K_MOV_RRM     = 3'd0;
   localparam logic [2:0] K_MOV_IMM_RM  = 3'd1;
   localparam logic [2:0] K_MOV_IMM_REG = 3'd2;
   localparam logic [2:0] K_MOV_MEM_ACC = 3'd3;
   localparam logic [2:0] K_MOV_ACC_MEM = 3'd4;
   localparam logic [2:0] K_ADD         = 3'd5;
   localparam logic [2:0] K_ADD_IMM_RM  = 3'd6;
   localparam logic [2:0] K_NONE        = 3'd7;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic [15:0] disp;
      logic [15:0] imm;
      logic [2:0]  bytes_seen;
      logic        dropping;
   } dec_state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  kind;
      logic [1:0]  mode;
      logic [2:0]  regf;
      logic [2:0]  rm;
      logic        dir;
      logic        wide;
      logic        sgn;
      logic [15:0] disp;
      logic [15:0] imm;
      logic [2:0]  len;
   } record_type;

   localparam dec_state_type STATE_CLEAR = '{
      phase: PH_OPCODE, opcode: 8'h00, modrm: 8'h00, disp: 16'h0000,
      imm: 16'h0000, bytes_seen: 3'd0, dropping: 1'b0};

endpackage

`default_nettype wire

// ----- rtl/x86dec_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module x86dec_step (
   input  x86dec_pkg::dec_state_type cur_state,
   input  logic [7:0]                code_byte,
   input  logic                      stream_end,
   output x86dec_pkg::dec_state_type next_state,
   output logic                      emit,
   output x86dec_pkg::record_type    rec
);
   import x86dec_pkg::*;

   function automatic logic [2:0] kind_of(input logic [7:0] op);
      logic [2:0] k;
      if ((op & 8'hFC) == 8'h88) k = K_MOV_RRM;
      else if ((op & 8'hFE) == 8'hC6) k = K_MOV_IMM_RM;
      else if ((op & 8'hF0) == 8'hB0) k = K_MOV_IMM_REG;
      else if ((op & 8'hFE) == 8'hA0) k = K_MOV_MEM_ACC;
      else if ((op & 8'hFE) == 8'hA2) k = K_MOV_ACC_MEM;
      else if ((op & 8'hFC) == 8'h00) k = K_ADD;
      else if ((op & 8'hFC) == 8'h80) k = K_ADD_IMM_RM;
      else k = K_NONE;
      return k;
   endfunction

   function automatic logic modrm_follows(input logic [2:0] k);
      return (k == K_MOV_RRM) || (k == K_MOV_IMM_RM) || (k == K_ADD) ||
             (k == K_ADD_IMM_RM);
   endfunction

   function automatic logic wide_of(input logic [2:0] k, input logic [7:0] op);
      return (k == K_MOV_IMM_REG) ? op[3] : op[0];
   endfunction

   function automatic logic sign_of(input logic [2:0] k, input logic [7:0] op);
      return (k == K_ADD_IMM_RM) ? op[1] : 1'b0;
   endfunction

   function automatic logic [1:0] disp_len(input logic [7:0] m);
      logic [1:0] n;
      if (m[7:6] == 2'd2 || (m[7:6] == 2'd0 && m[2:0] == 3'd6)) n = 2'd2;
      else if (m[7:6] == 2'd1) n = 2'd1;
      else n = 2'd0;
      return n;
   endfunction

   function automatic logic [1:0] imm_len(input logic [2:0] k, input logic [7:0] op);
      logic [1:0] n;
      if (k == K_MOV_MEM_ACC || k == K_MOV_ACC_MEM) n = 2'd2;
      else if (k == K_MOV_IMM_RM || k == K_MOV_IMM_REG || k == K_ADD_IMM_RM) begin
         if (sign_of(k, op) && wide_of(k, op)) n = 2'd1;
         else n = wide_of(k, op) ? 2'd2 : 2'd1;
      end else n = 2'd0;
      return n;
   endfunction

   function automatic logic [15:0] sext8(input logic [7:0] b);
      return {{8{b[7]}}, b};
   endfunction

   dec_state_type work;
   logic [2:0]    k;
   logic          done;
   logic          unk;
   logic          bad_phase;
   logic          mr;

   always_comb begin
      work      = cur_state;
      done      = 1'b0;
      unk       = 1'b0;
      bad_phase = 1'b0;
      work.bytes_seen = (cur_state.bytes_seen == 3'd7) ? 3'd7 : cur_state.bytes_seen + 3'd1;
      if (cur_state.phase == PH_OPCODE) begin
         work.opcode = code_byte;
      end
      k = kind_of(work.opcode);
      case (cur_state.phase)
         PH_OPCODE: begin
            if (k == K_NONE) begin
               unk = 1'b1;
            end else if (modrm_follows(k)) begin
               work.phase = PH_MODRM;
            end else if (imm_len(k, work.opcode) != 2'd0) begin
               work.phase = PH_IMM_LO;
            end else begin
               done = 1'b1;
            end
         end
         PH_MODRM: begin
            work.modrm = code_byte;
            if (k == K_ADD_IMM_RM && code_byte[5:3] != 3'd0) begin
               unk = 1'b1;
            end else if (disp_len(code_byte) != 2'd0) begin
               work.phase = PH_DISP_LO;
            end else if (imm_len(k, work.opcode) != 2'd0) begin
               work.phase = PH_IMM_LO;
            end else begin
               done = 1'b1;
            end
         end
         PH_DISP_LO: begin
            if (disp_len(work.modrm) == 2'd2) begin
               work.disp  = {8'h00, code_byte};
               work.phase = PH_DISP_HI;
            end else begin
               work.disp = sext8(code_byte);
               if (imm_len(k, work.opcode) != 2'd0) work.phase = PH_IMM_LO;
               else done = 1'b1;
            end
         end
         PH_DISP_HI: begin
            work.disp = {code_byte, cur_state.disp[7:0]};
            if (imm_len(k, work.opcode) != 2'd0) work.phase = PH_IMM_LO;
            else done = 1'b1;
         end
         PH_IMM_LO: begin
            if (imm_len(k, work.opcode) == 2'd2) begin
               work.imm   = {8'h00, code_byte};
               work.phase = PH_IMM_HI;
            end else begin
               work.imm = sext8(code_byte);
               done     = 1'b1;
            end
         end
         PH_IMM_HI: begin
            work.imm = {code_byte, cur_state.imm[7:0]};
            done     = 1'b1;
         end
         default: begin
            bad_phase = 1'b1;
         end
      endcase

      mr = modrm_follows(k) && (work.bytes_seen >= 3'd2);
      rec = '0;
      rec.len = work.bytes_seen;
      if (unk) begin
         rec.status = ST_UNKNOWN;
      end else begin
         rec.status = done ? ST_DECODED : ST_TRUNC;
         rec.kind   = k;
         if (mr) begin
            rec.mode = work.modrm[7:6];
            rec.regf = work.modrm[5:3];
            rec.rm   = work.modrm[2:0];
         end else if (k == K_MOV_IMM_REG) begin
            rec.regf = work.opcode[2:0];
         end
         if (k == K_MOV_RRM || k == K_MOV_MEM_ACC || k == K_MOV_ACC_MEM || k == K_ADD) begin
            rec.dir = work.opcode[1];
         end
         rec.wide = wide_of(k, work.opcode);
         rec.sgn  = sign_of(k, work.opcode);
         if (done) begin
            rec.disp = work.disp;
            rec.imm  = work.imm;
         end
      end

      emit       = 1'b0;
      next_state = work;
      if (cur_state.dropping) begin
         next_state = cur_state;
         if (stream_end) next_state = STATE_CLEAR;
      end else if (bad_phase) begin
         next_state = STATE_CLEAR;
      end else if (unk || done || stream_end) begin
         emit       = 1'b1;
         next_state = STATE_CLEAR;
         next_state.dropping = unk && !stream_end;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/x86_16bit_subset_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial decoder for a mov/add subset of 16-bit x86 code. One code byte is
// taken per cycle unless the input side stalls; each request passes an input
// register, the opcode/ModRM decode and field update, and lands in a result
// register from which its record is presented, so a full stream sustains one
// byte per clock while records are taken as they are offered.
// A record is produced per complete instruction (status decoded), per unknown
// opcode (status unknown, after which bytes are discarded through the byte
// flagged stream_end), or when stream_end cuts an instruction short (status
// truncated, displacement and immediate zero). The input side keeps accepting
// while a record waits, stalling only when both registers are full and the record is not taken.

module x86_16bit_subset_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_code_byte,
   input  logic               req_stream_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_kind,
   output logic [1:0]         rsp_mode_field,
   output logic [2:0]         rsp_reg_field,
   output logic [2:0]         rsp_rm_field,
   output logic               rsp_dir_bit,
   output logic               rsp_wide_bit,
   output logic               rsp_sign_bit,
   output logic signed [15:0] rsp_displacement,
   output logic signed [15:0] rsp_immediate,
   output logic [2:0]         rsp_length
);
   import x86dec_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_end_ff;
   dec_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   record_type    out_rec_ff;
   record_type    step_rec;
   logic          step_emit;
   logic          process;

   x86dec_step u_step (
      .cur_state  (state_ff),
      .code_byte  (in_byte_ff),
      .stream_end (in_end_ff),
      .next_state (state_in),
      .emit       (step_emit),
      .rec        (step_rec)
   );

   assign process   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (process && step_emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_code_byte;
         in_end_ff  <= req_stream_end;
      end
      if (process && step_emit) out_rec_ff <= step_rec;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_rec_ff.status;
   assign rsp_kind         = out_rec_ff.kind;
   assign rsp_mode_field   = out_rec_ff.mode;
   assign rsp_reg_field    = out_rec_ff.regf;
   assign rsp_rm_field     = out_rec_ff.rm;
   assign rsp_dir_bit      = out_rec_ff.dir;
   assign rsp_wide_bit     = out_rec_ff.wide;
   assign rsp_sign_bit     = out_rec_ff.sgn;
   assign rsp_displacement = signed'(out_rec_ff.disp);
   assign rsp_immediate    = signed'(out_rec_ff.imm);
   assign rsp_length       = out_rec_ff.len;

endmodule

`default_nettype wire

// ----- tb/x86_16bit_subset_decoder_tb.sv -----
`timescale 1ns / 1ps

module x86_16bit_subset_decoder_tb;
   import x86dec_pkg::*;

   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } byte_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_code_byte = 8'h00;
   logic              req_stream_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic [2:0]        rsp_kind;
   logic [1:0]        rsp_mode_field;
   logic [2:0]        rsp_reg_field;
   logic [2:0]        rsp_rm_field;
   logic              rsp_dir_bit;
   logic              rsp_wide_bit;
   logic              rsp_sign_bit;
   logic signed [15:0] rsp_displacement;
   logic signed [15:0] rsp_immediate;
   logic [2:0]        rsp_length;

   byte_item_type pending_bytes[$];
   record_type    expected_records[$];
   logic [7:0]    insn_bytes[$];
   byte_item_type next_item;
   record_type    seen_record;
   record_type    want_record;

   // decoder shadow state
   phase_type  dec_phase = PH_OPCODE;
   logic [7:0] dec_opcode = 8'h00;
   logic [7:0] dec_modrm = 8'h00;
   logic [15:0] dec_disp = 16'h0000;
   logic [15:0] dec_imm = 16'h0000;
   logic [2:0] dec_seen = 3'd0;
   logic       dec_dropping = 1'b0;

   int  send_idle = 29;
   int  recv_idle = 86;
   logic req_taken = 1'b0;
   int  stall_cycles = 0;
   int  bytes_accepted = 0;
   int  records_checked = 0;
   int  mismatch_count = 0;
   int  n_decoded = 0;
   int  n_unknown = 0;
   int  n_trunc = 0;

   x86_16bit_subset_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_byte   (req_code_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_kind        (rsp_kind),
      .rsp_mode_field  (rsp_mode_field),
      .rsp_reg_field   (rsp_reg_field),
      .rsp_rm_field    (rsp_rm_field),
      .rsp_dir_bit     (rsp_dir_bit),
      .rsp_wide_bit    (rsp_wide_bit),
      .rsp_sign_bit    (rsp_sign_bit),
      .rsp_displacement(rsp_displacement),
      .rsp_immediate   (rsp_immediate),
      .rsp_length      (rsp_length)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [2:0] kind_for(input logic [7:0] op);
      if ((op & 8'hFC) == 8'h88) return K_MOV_RRM;
      if ((op & 8'hFE) == 8'hC6) return K_MOV_IMM_RM;
      if ((op & 8'hF0) == 8'hB0) return K_MOV_IMM_REG;
      if ((op & 8'hFE) == 8'hA0) return K_MOV_MEM_ACC;
      if ((op & 8'hFE) == 8'hA2) return K_MOV_ACC_MEM;
      if ((op & 8'hFC) == 8'h00) return K_ADD;
      if ((op & 8'hFC) == 8'h80) return K_ADD_IMM_RM;
      return K_NONE;
   endfunction

   function automatic logic takes_modrm(input logic [2:0] k);
      return k == K_MOV_RRM || k == K_MOV_IMM_RM || k == K_ADD || k == K_ADD_IMM_RM;
   endfunction

   function automatic logic wide_for(input logic [2:0] k, input logic [7:0] op);
      return (k == K_MOV_IMM_REG) ? op[3] : op[0];
   endfunction

   function automatic logic sign_for(input logic [2:0] k, input logic [7:0] op);
      return (k == K_ADD_IMM_RM) ? op[1] : 1'b0;
   endfunction

   function automatic int disp_bytes(input logic [7:0] m);
      if (m[7:6] == 2'd2 || (m[7:6] == 2'd0 && m[2:0] == 3'd6)) return 2;
      if (m[7:6] == 2'd1) return 1;
      return 0;
   endfunction

   function automatic int imm_bytes(input logic [2:0] k, input logic [7:0] op);
      if (k == K_MOV_MEM_ACC || k == K_MOV_ACC_MEM) return 2;
      if (k == K_MOV_IMM_RM || k == K_MOV_IMM_REG || k == K_ADD_IMM_RM) begin
         if (sign_for(k, op) && wide_for(k, op)) return 1;
         return wide_for(k, op) ? 2 : 1;
      end
      return 0;
   endfunction

   function automatic record_type make_record(input logic [1:0] status, input logic full);
      record_type r;
      logic [2:0] k;
      r = '0;
      k = kind_for(dec_opcode);
      r.status = status;
      r.len = dec_seen;
      if (status == ST_UNKNOWN) return r;
      r.kind = k;
      if (takes_modrm(k) && dec_seen >= 3'd2) begin
         r.mode = dec_modrm[7:6];
         r.regf = dec_modrm[5:3];
         r.rm = dec_modrm[2:0];
      end else if (k == K_MOV_IMM_REG) begin
         r.regf = dec_opcode[2:0];
      end
      if (k == K_MOV_RRM || k == K_MOV_MEM_ACC || k == K_MOV_ACC_MEM || k == K_ADD)
         r.dir = dec_opcode[1];
      r.wide = wide_for(k, dec_opcode);
      r.sgn = sign_for(k, dec_opcode);
      if (full) begin
         r.disp = dec_disp;
         r.imm = dec_imm;
      end
      return r;
   endfunction

   function automatic string fmt_record(input record_type r);
      return $sformatf(
         "st=%0d kind=%0d mod=%0d reg=%0d rm=%0d d=%0b w=%0b s=%0b disp=%h imm=%h len=%0d",
         r.status, r.kind, r.mode, r.regf, r.rm, r.dir, r.wide, r.sgn, r.disp, r.imm, r.len);
   endfunction

   task automatic clear_decoder();
      dec_phase = PH_OPCODE;
      dec_opcode = 8'h00;
      dec_modrm = 8'h00;
      dec_disp = 16'h0000;
      dec_imm = 16'h0000;
      dec_seen = 3'd0;
   endtask

   function automatic logic enter_imm();
      if (imm_bytes(kind_for(dec_opcode), dec_opcode) > 0) begin
         dec_phase = PH_IMM_LO;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic reject_opcode(input logic last);
      expected_records.push_back(make_record(ST_UNKNOWN, 1'b0));
      clear_decoder();
      dec_dropping = !last;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic done;
      done = 1'b0;
      if (dec_dropping) begin
         if (last) begin
            dec_dropping = 1'b0;
            clear_decoder();
         end
         return;
      end
      if (dec_seen < 3'd7) dec_seen = dec_seen + 3'd1;
      case (dec_phase)
         PH_OPCODE: begin
            dec_opcode = b;
            if (kind_for(b) == K_NONE) begin
               reject_opcode(last);
               return;
            end
            if (takes_modrm(kind_for(b))) dec_phase = PH_MODRM;
            else done = enter_imm();
         end
         PH_MODRM: begin
            dec_modrm = b;
            if (kind_for(dec_opcode) == K_ADD_IMM_RM && b[5:3] != 3'd0) begin
               reject_opcode(last);
               return;
            end
            if (disp_bytes(b) > 0) dec_phase = PH_DISP_LO;
            else done = enter_imm();
         end
         PH_DISP_LO: begin
            if (disp_bytes(dec_modrm) == 2) begin
               dec_disp = {8'h00, b};
               dec_phase = PH_DISP_HI;
            end else begin
               dec_disp = {{8{b[7]}}, b};
               done = enter_imm();
            end
         end
         PH_DISP_HI: begin
            dec_disp[15:8] = b;
            done = enter_imm();
         end
         PH_IMM_LO: begin
            if (imm_bytes(kind_for(dec_opcode), dec_opcode) == 2) begin
               dec_imm = {8'h00, b};
               dec_phase = PH_IMM_HI;
            end else begin
               dec_imm = {{8{b[7]}}, b};
               done = 1'b1;
            end
         end
         PH_IMM_HI: begin
            dec_imm[15:8] = b;
            done = 1'b1;
         end
         default: begin
            clear_decoder();
            return;
         end
      endcase
      if (done) begin
         expected_records.push_back(make_record(ST_DECODED, 1'b1));
         clear_decoder();
      end else if (last) begin
         expected_records.push_back(make_record(ST_TRUNC, 1'b0));
         clear_decoder();
      end
   endtask

   task automatic push_byte(input logic [7:0] code, input logic last);
      pending_bytes.push_back('{code: code, last: last});
   endtask

   // well-formed instruction with random fields
   task automatic make_insn();
      logic [7:0] op;
      logic [7:0] m;
      logic [2:0] k;
      int n;
      insn_bytes.delete();
      k = 3'($urandom_range(6));
      case (k)
         K_MOV_RRM:     op = 8'h88 | 8'($urandom_range(3));
         K_MOV_IMM_RM:  op = 8'hC6 | 8'($urandom_range(1));
         K_MOV_IMM_REG: op = 8'hB0 | 8'($urandom_range(15));
         K_MOV_MEM_ACC: op = 8'hA0 | 8'($urandom_range(1));
         K_MOV_ACC_MEM: op = 8'hA2 | 8'($urandom_range(1));
         K_ADD:         op = 8'($urandom_range(3));
         default:       op = 8'h80 | 8'($urandom_range(3));
      endcase
      insn_bytes.push_back(op);
      if (takes_modrm(k)) begin
         m = 8'($urandom_range(255));
         if ($urandom_range(7) == 0) m = {2'd0, m[5:3], 3'd6};
         if (k == K_ADD_IMM_RM) m[5:3] = 3'd0;
         insn_bytes.push_back(m);
         n = disp_bytes(m);
         repeat (n) insn_bytes.push_back(8'($urandom_range(255)));
      end
      n = imm_bytes(k, op);
      repeat (n) insn_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic push_random_items(input int n);
      int count;
      int pick;
      int roll;
      int cut;
      int junk;
      logic [7:0] op;
      logic [7:0] m;
      count = 0;
      while (count < n) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            make_insn();
            roll = $urandom_range(99);
            cut = (roll < 8) ? $urandom_range(insn_bytes.size() - 2) : insn_bytes.size() - 1;
            for (int i = 0; i <= cut; i++) push_byte(insn_bytes[i], roll < 18 && i == cut);
            count += cut + 1;
         end else if (pick < 85) begin
            junk = $urandom_range(3);
            if ($urandom_range(1)) begin
               op = 8'($urandom_range(255));
               while (kind_for(op) != K_NONE) op = 8'($urandom_range(255));
               push_byte(op, junk == 0);
               count += 1;
            end else begin
               m = 8'($urandom_range(255));
               m[5:3] = 3'($urandom_range(7, 1));
               push_byte(8'h80 | 8'($urandom_range(3)), 1'b0);
               push_byte(m, junk == 0);
               count += 2;
            end
            for (int i = 1; i <= junk; i++) push_byte(8'($urandom_range(255)), i == junk);
            count += junk;
         end else begin
            push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            count += 1;
         end
      end
   endtask

   task automatic drain();
      wait (pending_bytes.size() == 0 && !req_valid);
      wait (expected_records.size() == 0);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
               next_item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_code_byte <= next_item.code;
               req_stream_end <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_record.status = rsp_status;
            seen_record.kind = rsp_kind;
            seen_record.mode = rsp_mode_field;
            seen_record.regf = rsp_reg_field;
            seen_record.rm = rsp_rm_field;
            seen_record.dir = rsp_dir_bit;
            seen_record.wide = rsp_wide_bit;
            seen_record.sgn = rsp_sign_bit;
            seen_record.disp = rsp_displacement;
            seen_record.imm = rsp_immediate;
            seen_record.len = rsp_length;
            if (expected_records.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected record %s", $realtime, fmt_record(seen_record));
            end else begin
               want_record = expected_records.pop_front();
               records_checked++;
               case (want_record.status)
                  ST_DECODED: n_decoded++;
                  ST_UNKNOWN: n_unknown++;
                  default:    n_trunc++;
               endcase
               if (seen_record !== want_record) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                        fmt_record(want_record), fmt_record(seen_record));
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_byte(req_code_byte, req_stream_end);
            bytes_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: each kind, field extremes, error and cut-off cases
      push_byte(8'h89, 1'b0); push_byte(8'hC3, 1'b0);
      push_byte(8'h03, 1'b0); push_byte(8'h46, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'hC7, 1'b0); push_byte(8'h86, 1'b0); push_byte(8'h34, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h7F, 1'b0);
      push_byte(8'hBF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'hA0, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'hA3, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h83, 1'b0); push_byte(8'h06, 1'b0); push_byte(8'h78, 1'b0);
      push_byte(8'h56, 1'b0);
      push_byte(8'h80, 1'b1);
      push_byte(8'hFF, 1'b0); push_byte(8'h12, 1'b1);
      push_byte(8'h80, 1'b0); push_byte(8'hF8, 1'b1);
      push_byte(8'hC7, 1'b0); push_byte(8'h05, 1'b1);
      push_byte(8'h80, 1'b1);
      push_byte(8'h0F, 1'b1);
      drain();

      push_random_items(135);
      drain();
      send_idle = 86;
      recv_idle = 29;
      push_random_items(135);
      drain();
      send_idle = 0;
      recv_idle = 0;
      push_random_items(135);
      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d code bytes; checked %0d records:", bytes_accepted, records_checked);
      $display("  %0d decoded, %0d unknown opcode, %0d truncated",
         n_decoded, n_unknown, n_trunc);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
